### design/sacfl_pkg.sv
// sacfl_pkg: shared constants and types for the fifo-replacement set-associative cache lookup
// used by the channel interfaces, the entry store and the top level
package sacfl_pkg;

	localparam int ENTRIES_LOG2_DEF = 8;
	localparam int ADDR_W           = 32;
	localparam int CFG_W            = 4;
	localparam int WAY_W            = 8;
	localparam int CNT_W            = 32;

	localparam logic [CFG_W-1:0] WAYS_LOG2_RST = CFG_W'(2);

	typedef struct packed {
		logic rd;
		logic wr;
	} sacfl_mem_ctl_t;

endpackage

### design/sacfl_addr_if.sv
// sacfl_addr_if: request channel, one address word per handshake
// depends on sacfl_pkg
interface sacfl_addr_if import sacfl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output address, input ready);
	modport sink   (input valid, input address, output ready);
endinterface

### design/sacfl_res_if.sv
// sacfl_res_if: result channel, one lookup result word per handshake
// depends on sacfl_pkg
interface sacfl_res_if import sacfl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             hit;
	logic [WAY_W-1:0] way_used;
	logic [CNT_W-1:0] hit_total;
	logic [CNT_W-1:0] miss_total;

	modport source (output valid, output hit, output way_used, output hit_total,
		output miss_total, input ready);
	modport sink   (input valid, input hit, input way_used, input hit_total,
		input miss_total, output ready);
endinterface

### design/set_assoc_cache_fifo_lookup.sv
// set_assoc_cache_fifo_lookup: set-associative cache hit/miss lookup with fifo replacement
// depends on sacfl_pkg, sacfl_addr_if, sacfl_res_if and sacfl_store
//
// Each lookup handles one address, with k as ways_log2 clipped to ENTRIES_LOG2: the 2^k ways
// of the selected set are read one per cycle through the single-port entry memory and checked
// by one match/age compare unit, then the write state fills or replaces on a miss and loads
// the result word into the output register. A new address is taken only while no lookup is
// in progress; a result waiting in the output register does not block acceptance, but the
// write step of the next lookup holds until that word is taken. Valid bits reset at once, so
// no clearing pass follows reset. ways_log2 may be written only while the block is idle.
module set_assoc_cache_fifo_lookup import sacfl_pkg::*; #(
	parameter int ENTRIES_LOG2 = ENTRIES_LOG2_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	sacfl_addr_if.sink        req,
	sacfl_res_if.source       rsp
);

	localparam int E   = ENTRIES_LOG2;
	localparam int K_W = $clog2(E + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  cfg_q;
	logic [ADDR_W-1:0] addr_q;
	logic [E-1:0]      cnt_q;
	logic              issue_done_q;
	logic              vld_s1;
	logic              last_s1;
	logic [E-1:0]      way_s1;
	logic              hit_found_q;
	logic [E-1:0]      hit_way_q;
	logic              inv_found_q;
	logic [E-1:0]      inv_way_q;
	logic [CNT_W-1:0]  best_age_q;
	logic [E-1:0]      best_way_q;
	logic [CNT_W-1:0]  step_q;
	logic [CNT_W-1:0]  hits_q;
	logic [CNT_W-1:0]  misses_q;
	logic              out_valid_q;
	logic              out_hit_q;
	logic [WAY_W-1:0]  out_way_q;
	logic [CNT_W-1:0]  out_hits_q;
	logic [CNT_W-1:0]  out_misses_q;

	logic [K_W-1:0]    k_eff;
	logic [E-1:0]      way_mask;
	logic [E-1:0]      base;
	logic [E-1:0]      chosen;
	logic [E-1:0]      idx;
	logic              accept;
	logic              commit;
	logic              issue;
	logic              miss;
	logic              match;
	logic [CNT_W-1:0]  age;
	sacfl_mem_ctl_t    mem_ctl;
	logic [ADDR_W-1:0] rd_addr_s1;
	logic [CNT_W-1:0]  rd_stamp_s1;
	logic              rd_valid_s1;

	// associativity clipped so at least one set remains
	assign k_eff    = (cfg_q > CFG_W'(E)) ? K_W'(E) : K_W'(cfg_q);
	assign way_mask = ~({E{1'b1}} << k_eff);
	assign base     = (addr_q[E-1:0] & ({E{1'b1}} >> k_eff)) << k_eff;

	assign accept = req.valid && req.ready;
	assign commit = (state_q == ST_WRITE) && (!out_valid_q || rsp.ready);
	assign issue  = (state_q == ST_SCAN) && !issue_done_q;
	assign miss   = !hit_found_q;

	always_comb begin
		priority if (hit_found_q) begin
			chosen = hit_way_q;
		end else if (inv_found_q) begin
			chosen = inv_way_q;
		end else begin
			chosen = best_way_q;
		end
	end

	assign idx        = base | ((state_q == ST_WRITE) ? chosen : cnt_q);
	assign mem_ctl.rd = issue;
	assign mem_ctl.wr = commit && miss;

	assign match = rd_valid_s1 && (rd_addr_s1 == addr_q);
	assign age   = step_q - rd_stamp_s1;

	sacfl_store #(.ENTRIES_LOG2(E)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mem_ctl),
		.idx      (idx),
		.wr_addr  (addr_q),
		.wr_stamp (step_q),
		.addr_s1  (rd_addr_s1),
		.stamp_s1 (rd_stamp_s1),
		.valid_s1 (rd_valid_s1)
	);

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = out_hit_q;
	assign rsp.way_used   = out_way_q;
	assign rsp.hit_total  = out_hits_q;
	assign rsp.miss_total = out_misses_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= WAYS_LOG2_RST;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			last_s1      <= 1'b0;
			hit_found_q  <= 1'b0;
			inv_found_q  <= 1'b0;
			step_q       <= '0;
			hits_q       <= '0;
			misses_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q        <= '0;
						issue_done_q <= 1'b0;
						hit_found_q  <= 1'b0;
						inv_found_q  <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						last_s1 <= (cnt_q == way_mask);
						cnt_q   <= cnt_q + E'(1);
						if (cnt_q == way_mask) begin
							issue_done_q <= 1'b1;
						end
					end
					if (vld_s1) begin
						if (!hit_found_q && match) begin
							hit_found_q <= 1'b1;
						end
						if (!inv_found_q && !rd_valid_s1) begin
							inv_found_q <= 1'b1;
						end
						if (last_s1) begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					if (commit) begin
						step_q <= step_q + CNT_W'(1);
						if (miss) begin
							misses_q <= misses_q + CNT_W'(1);
						end else begin
							hits_q <= hits_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= req.address;
		end
		if (issue) begin
			way_s1 <= cnt_q;
		end
		if (state_q == ST_SCAN && vld_s1) begin
			if (!hit_found_q && match) begin
				hit_way_q <= way_s1;
			end
			if (!inv_found_q && !rd_valid_s1) begin
				inv_way_q <= way_s1;
			end
			if (way_s1 == '0 || age > best_age_q) begin
				best_age_q <= age;
				best_way_q <= way_s1;
			end
		end
		if (commit) begin
			out_hit_q    <= hit_found_q;
			out_way_q    <= WAY_W'(chosen);
			out_hits_q   <= miss ? hits_q : hits_q + CNT_W'(1);
			out_misses_q <= miss ? misses_q + CNT_W'(1) : misses_q;
		end
	end

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN))
		else $error("accepted address did not start a set scan");

	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (rsp.valid && (rsp.hit_total + rsp.miss_total == step_q)))
		else $error("result word does not match the access count");

	a_one_count_per_access: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (CNT_W'(hits_q + misses_q) == CNT_W'($past(hits_q) + $past(misses_q) + 1)))
		else $error("hit and miss totals did not advance by exactly one");

	a_scan_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !issue_done_q) |-> ((cnt_q & ~way_mask) == '0))
		else $error("way counter left the selected set");

	a_no_write_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.wr |-> (!mem_ctl.rd && state_q == ST_WRITE && !hit_found_q))
		else $error("entry written outside a miss fill");

endmodule

### design/sacfl_store.sv
// sacfl_store: entry storage, single-port address and stamp memories plus valid bits
// depends on sacfl_pkg
module sacfl_store import sacfl_pkg::*; #(
	parameter int ENTRIES_LOG2 = ENTRIES_LOG2_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sacfl_mem_ctl_t          ctl,
	input  logic [ENTRIES_LOG2-1:0] idx,
	input  logic [ADDR_W-1:0]       wr_addr,
	input  logic [CNT_W-1:0]        wr_stamp,
	output logic [ADDR_W-1:0]       addr_s1,
	output logic [CNT_W-1:0]        stamp_s1,
	output logic                    valid_s1
);

	localparam int DEPTH = 1 << ENTRIES_LOG2;

	logic [ADDR_W-1:0] addr_mem [DEPTH];
	logic [CNT_W-1:0]  stamp_mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			addr_mem[idx]  <= wr_addr;
			stamp_mem[idx] <= wr_stamp;
		end
		if (ctl.rd) begin
			addr_s1  <= addr_mem[idx];
			stamp_s1 <= stamp_mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (ctl.wr) begin
				valid_q[idx] <= 1'b1;
			end
			if (ctl.rd) begin
				valid_s1 <= valid_q[idx];
			end
		end
	end

endmodule
